/* rtl/core/union_find_set_size_macros.svh */
// Assertion macros shared by the union-find RTL.
`ifndef UNION_FIND_SET_SIZE_MACROS_SVH
`define UNION_FIND_SET_SIZE_MACROS_SVH

// Combinational implication, checked at every rising edge outside reset.
`define UFSS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define UFSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/ufss_pkg.sv */
// Constants for the union-find set-size engine.
package ufss_pkg;

  localparam int unsigned NODES_DEFAULT = 1024;
  localparam int unsigned ID_IN_W       = 10;
  localparam int unsigned SIZE_W        = 11;
  localparam int unsigned RANK_W        = 4;
  localparam int unsigned TAG_W         = 8;

  localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};
  localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};

endpackage

/* rtl/core/union_find_set_size.sv */
// Union-find engine: union by rank with path compression, returns the merged set size.
// A pair passes S_MK_A, S_MK_B, S_CHK_B, find and compression walks per node, S_LINK1,
// S_LINK2 (skipped when both nodes share a root) and S_DONE, after S_FOLD when an id is
// not below NODES. One pair is in flight at a time, so the next input transfer can come
// in the cycle after the result loads, later if out_stall_i holds it. Reset sweeps the
// seen tags with input stalled; every 255th fresh_table does too.
`include "union_find_set_size_macros.svh"

module union_find_set_size #(
  parameter int unsigned NODES = ufss_pkg::NODES_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ufss_pkg::ID_IN_W-1:0]  node_a_i,
  input  logic [ufss_pkg::ID_IN_W-1:0]  node_b_i,
  input  logic                          fresh_table_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ufss_pkg::SIZE_W-1:0]   set_size_o
);

  localparam int unsigned IdW    = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned InW    = ufss_pkg::ID_IN_W;
  localparam int unsigned SzW    = ufss_pkg::SIZE_W;
  localparam int unsigned RkW    = ufss_pkg::RANK_W;
  localparam int unsigned TagW   = ufss_pkg::TAG_W;
  // Reciprocal of NODES, exact for every id of InW bits.
  localparam int unsigned FoldSh  = InW + IdW;
  localparam int unsigned FoldMul = ((32'd1 << FoldSh) + NODES - 1) / NODES;

  typedef struct packed {
    logic [TagW-1:0] tag;
    logic [IdW-1:0]  parent;
    logic [SzW-1:0]  size;
    logic [RkW-1:0]  rank;
  } node_rec_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FOLD,
    S_MK_A,
    S_MK_B,
    S_CHK_B,
    S_FIND,
    S_COMP,
    S_LINK1,
    S_LINK2,
    S_DONE
  } state_e;

  state_e            state_q;
  logic [TagW-1:0]   epoch_q;
  logic [IdW-1:0]    clr_cnt_q;
  logic              item_q;
  logic [InW-1:0]    a_q, b_q;
  logic [IdW-1:0]    cur_q;
  logic              phase_q;
  logic [IdW-1:0]    root_a_q, root_b_q;
  logic [SzW-1:0]    size_a_q, size_b_q;
  logic [RkW-1:0]    rank_a_q, rank_b_q;
  node_rec_t         win_rec_q;
  logic [SzW-1:0]    result_q;
  logic              out_valid_q;
  logic [SzW-1:0]    out_data_q;

  node_rec_t mem [NODES];
  node_rec_t rd_q;

  logic [IdW-1:0] rd_addr, wr_addr;
  logic           wr_en;
  node_rec_t      wr_data;

  logic [IdW-1:0] a_id, b_id, start_id, root_cur;
  logic           unseen, at_root, next_is_root;
  logic           fold_in, fold_q;
  logic [31:0]    a_quot, b_quot;
  logic [InW-1:0] a_fold, b_fold;
  logic [SzW:0]   sum_full;
  logic [SzW-1:0] sum_sat;
  logic           a_wins;
  logic [RkW-1:0] new_rank_b;
  logic           out_load;

  assign a_id         = IdW'(a_q);
  assign b_id         = IdW'(b_q);
  assign start_id     = phase_q ? b_id : a_id;
  assign root_cur     = phase_q ? root_b_q : root_a_q;
  assign unseen       = (rd_q.tag != epoch_q);
  assign at_root      = (rd_q.parent == cur_q);
  assign next_is_root = (rd_q.parent == root_cur);

  // Ids at or above NODES are reduced in the S_FOLD state by a reciprocal multiplication.
  assign fold_in = (32'(node_a_i) >= NODES) || (32'(node_b_i) >= NODES);
  assign fold_q  = (32'(a_q) >= NODES) || (32'(b_q) >= NODES);
  assign a_quot  = (32'(a_q) * FoldMul) >> FoldSh;
  assign b_quot  = (32'(b_q) * FoldMul) >> FoldSh;
  assign a_fold  = InW'(32'(a_q) - a_quot * NODES);
  assign b_fold  = InW'(32'(b_q) - b_quot * NODES);

  assign sum_full   = {1'b0, size_a_q} + {1'b0, size_b_q};
  assign sum_sat    = (sum_full > {1'b0, ufss_pkg::SIZE_MAX}) ? ufss_pkg::SIZE_MAX
                                                             : sum_full[SzW-1:0];
  assign a_wins     = (rank_a_q > rank_b_q);
  assign new_rank_b = ((rank_a_q == rank_b_q) && (rank_b_q != ufss_pkg::RANK_MAX))
                      ? rank_b_q + RkW'(1) : rank_b_q;

  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // Memory port control.
  always_comb begin
    rd_addr = cur_q;
    wr_en   = 1'b0;
    wr_addr = cur_q;
    wr_data = rd_q;
    unique case (state_q)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_q;
        wr_data = '0;
      end
      S_MK_A: begin
        rd_addr = a_id;
      end
      S_MK_B: begin
        rd_addr = b_id;
        if (unseen) begin
          wr_en   = 1'b1;
          wr_addr = a_id;
          wr_data = '{tag: epoch_q, parent: a_id, size: SzW'(1), rank: '0};
        end
      end
      S_CHK_B: begin
        rd_addr = a_id;
        if (unseen) begin
          wr_en   = 1'b1;
          wr_addr = b_id;
          wr_data = '{tag: epoch_q, parent: b_id, size: SzW'(1), rank: '0};
        end
      end
      S_FIND: begin
        if (!at_root) begin
          rd_addr = rd_q.parent;
        end else if (start_id != cur_q) begin
          rd_addr = start_id;
        end else if (!phase_q) begin
          rd_addr = b_id;
        end
      end
      S_COMP: begin
        wr_en          = 1'b1;
        wr_addr        = cur_q;
        wr_data.parent = root_cur;
        if (!next_is_root) begin
          rd_addr = rd_q.parent;
        end else if (!phase_q) begin
          rd_addr = b_id;
        end
      end
      S_LINK1: begin
        if (root_a_q != root_b_q) begin
          wr_en = 1'b1;
          if (a_wins) begin
            wr_addr = root_b_q;
            wr_data = '{tag: epoch_q, parent: root_a_q, size: size_b_q, rank: rank_b_q};
          end else begin
            wr_addr = root_a_q;
            wr_data = '{tag: epoch_q, parent: root_b_q, size: size_a_q, rank: rank_a_q};
          end
        end
      end
      S_LINK2: begin
        wr_en   = 1'b1;
        wr_addr = win_rec_q.parent;
        wr_data = win_rec_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      epoch_q     <= '0;
      clr_cnt_q   <= '0;
      item_q      <= 1'b0;
      a_q         <= '0;
      b_q         <= '0;
      cur_q       <= '0;
      phase_q     <= 1'b0;
      root_a_q    <= '0;
      root_b_q    <= '0;
      size_a_q    <= '0;
      size_b_q    <= '0;
      rank_a_q    <= '0;
      rank_b_q    <= '0;
      win_rec_q   <= '0;
      result_q    <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + IdW'(1);
          if (clr_cnt_q == IdW'(NODES - 1)) begin
            clr_cnt_q <= '0;
            epoch_q   <= TagW'(1);
            if (!item_q) begin
              state_q <= S_IDLE;
            end else if (fold_q) begin
              state_q <= S_FOLD;
            end else begin
              state_q <= S_MK_A;
            end
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            a_q      <= node_a_i;
            b_q      <= node_b_i;
            item_q   <= 1'b1;
            // A wrapping epoch would revive stale tags, so sweep them instead.
            if (fresh_table_i && (epoch_q == {TagW{1'b1}})) begin
              state_q <= S_CLEAR;
            end else begin
              if (fresh_table_i) begin
                epoch_q <= epoch_q + TagW'(1);
              end
              state_q <= fold_in ? S_FOLD : S_MK_A;
            end
          end
        end
        S_FOLD: begin
          a_q     <= a_fold;
          b_q     <= b_fold;
          state_q <= S_MK_A;
        end
        S_MK_A: begin
          state_q <= S_MK_B;
        end
        S_MK_B: begin
          state_q <= S_CHK_B;
        end
        S_CHK_B: begin
          cur_q   <= a_id;
          phase_q <= 1'b0;
          state_q <= S_FIND;
        end
        S_FIND: begin
          if (at_root) begin
            if (!phase_q) begin
              root_a_q <= cur_q;
              size_a_q <= rd_q.size;
              rank_a_q <= rd_q.rank;
            end else begin
              root_b_q <= cur_q;
              size_b_q <= rd_q.size;
              rank_b_q <= rd_q.rank;
            end
            if (start_id != cur_q) begin
              cur_q   <= start_id;
              state_q <= S_COMP;
            end else if (!phase_q) begin
              phase_q <= 1'b1;
              cur_q   <= b_id;
            end else begin
              state_q <= S_LINK1;
            end
          end else begin
            cur_q <= rd_q.parent;
          end
        end
        S_COMP: begin
          if (next_is_root) begin
            if (!phase_q) begin
              phase_q <= 1'b1;
              cur_q   <= b_id;
              state_q <= S_FIND;
            end else begin
              state_q <= S_LINK1;
            end
          end else begin
            cur_q <= rd_q.parent;
          end
        end
        S_LINK1: begin
          if (root_a_q == root_b_q) begin
            result_q <= size_a_q;
            state_q  <= S_DONE;
          end else begin
            result_q <= sum_sat;
            if (a_wins) begin
              win_rec_q <= '{tag: epoch_q, parent: root_a_q, size: sum_sat, rank: rank_a_q};
            end else begin
              win_rec_q <= '{tag: epoch_q, parent: root_b_q, size: sum_sat,
                             rank: new_rank_b};
            end
            state_q <= S_LINK2;
          end
        end
        S_LINK2: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            out_data_q  <= result_q;
            item_q      <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign set_size_o  = out_data_q;

  `UFSS_ASSERT_NEXT(a_accept_leaves_idle, in_valid_i && !in_stall_o, state_q != S_IDLE,
                    "accepted transfer did not start work")
  `UFSS_ASSERT_NEXT(a_done_loads_output, out_load, out_valid_o && (state_q == S_IDLE),
                    "finished result not presented")
  `UFSS_ASSERT_IMPL(a_epoch_live, state_q != S_CLEAR, epoch_q != '0,
                    "seen epoch is zero outside the sweep")
  `UFSS_ASSERT_IMPL(a_link_roots_differ, state_q == S_LINK2, root_a_q != root_b_q,
                    "second link write with equal roots")
  `UFSS_ASSERT_IMPL(a_comp_not_root, state_q == S_COMP, cur_q != root_cur,
                    "path compression reached the root itself")

endmodule

/* test/union_find_set_size_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the union-find set-size engine with its own predictor.
module union_find_set_size_test;

  localparam int unsigned       ID_IN_W  = ufss_pkg::ID_IN_W;
  localparam int unsigned       SIZE_W   = ufss_pkg::SIZE_W;
  localparam int unsigned       RANK_W   = ufss_pkg::RANK_W;
  localparam logic [SIZE_W-1:0] SIZE_MAX = ufss_pkg::SIZE_MAX;
  localparam logic [RANK_W-1:0] RANK_MAX = ufss_pkg::RANK_MAX;
  localparam int unsigned       NODES    = ufss_pkg::NODES_DEFAULT;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic [ID_IN_W-1:0] node_a      = '0;
  logic [ID_IN_W-1:0] node_b      = '0;
  logic               fresh_table = 1'b0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic [SIZE_W-1:0]  set_size;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int mismatches    = 0;

  logic [SIZE_W-1:0] pending_sizes[$];

  // Predictor copy of the disjoint-set tables.
  logic               seen_tbl   [NODES];
  logic [ID_IN_W-1:0] parent_tbl [NODES];
  logic [SIZE_W-1:0]  size_tbl   [NODES];
  logic [RANK_W-1:0]  rank_tbl   [NODES];

  union_find_set_size #(
    .NODES(NODES)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .node_a_i     (node_a),
    .node_b_i     (node_b),
    .fresh_table_i(fresh_table),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .set_size_o   (set_size)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  initial begin
    for (int i = 0; i < NODES; i++) begin
      seen_tbl[i] = 1'b0;
    end
  end

  function automatic void add_if_unseen(logic [ID_IN_W-1:0] n);
    if (!seen_tbl[n]) begin
      seen_tbl[n]   = 1'b1;
      parent_tbl[n] = n;
      size_tbl[n]   = SIZE_W'(1);
      rank_tbl[n]   = '0;
    end
  endfunction

  // Walks to the root, then points every node on the path straight at it.
  function automatic logic [ID_IN_W-1:0] root_with_compress(logic [ID_IN_W-1:0] n);
    logic [ID_IN_W-1:0] root;
    logic [ID_IN_W-1:0] next_node;
    int                 steps;
    root  = n;
    steps = 0;
    while (parent_tbl[root] != root && steps < NODES) begin
      root = parent_tbl[root];
      steps++;
    end
    steps = 0;
    while (n != root && steps < NODES) begin
      next_node     = parent_tbl[n];
      parent_tbl[n] = root;
      n             = next_node;
      steps++;
    end
    return root;
  endfunction

  function automatic logic [SIZE_W-1:0] predict_set_size(logic [ID_IN_W-1:0] a,
                                                         logic [ID_IN_W-1:0] b,
                                                         logic fresh);
    logic [ID_IN_W-1:0] root_a;
    logic [ID_IN_W-1:0] root_b;
    logic [SIZE_W:0]    sum;
    a = ID_IN_W'(a % NODES);
    b = ID_IN_W'(b % NODES);
    if (fresh) begin
      for (int i = 0; i < NODES; i++) begin
        seen_tbl[i] = 1'b0;
      end
    end
    add_if_unseen(a);
    add_if_unseen(b);
    root_a = root_with_compress(a);
    root_b = root_with_compress(b);
    if (root_a == root_b) begin
      return size_tbl[root_a];
    end
    sum = {1'b0, size_tbl[root_a]} + {1'b0, size_tbl[root_b]};
    if (sum > {1'b0, SIZE_MAX}) begin
      sum = {1'b0, SIZE_MAX};
    end
    if (rank_tbl[root_a] > rank_tbl[root_b]) begin
      parent_tbl[root_b] = root_a;
      size_tbl[root_a]   = sum[SIZE_W-1:0];
    end else begin
      parent_tbl[root_a] = root_b;
      size_tbl[root_b]   = sum[SIZE_W-1:0];
      if (rank_tbl[root_a] == rank_tbl[root_b] && rank_tbl[root_b] < RANK_MAX) begin
        rank_tbl[root_b] = rank_tbl[root_b] + RANK_W'(1);
      end
    end
    return sum[SIZE_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
  endtask

  // Sends one pair and records its expected size once the transfer happens.
  task automatic send_pair(input logic [ID_IN_W-1:0] a, input logic [ID_IN_W-1:0] b,
                           input logic fresh);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    node_a      <= a;
    node_b      <= b;
    fresh_table <= fresh;
    do begin
      @(posedge clk_i);
    end while (in_stall);
    pending_sizes = {pending_sizes, predict_set_size(a, b, fresh)};
  endtask

  // Biased toward a small id window so that sets grow deep and finds repeat.
  function automatic logic [ID_IN_W-1:0] pick_node();
    if ($urandom_range(0, 9) < 3) begin
      return ID_IN_W'($urandom_range(0, 31));
    end
    return ID_IN_W'($urandom_range(0, NODES - 1));
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_sizes.size() == 0) begin
        report_mismatch($sformatf("set_size %0d with no pair pending", set_size));
      end else begin
        if (set_size !== pending_sizes[0]) begin
          report_mismatch($sformatf("set_size got %0d, expected %0d",
                                    set_size, pending_sizes[0]));
        end
        void'(pending_sizes.pop_front());
      end
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic test_directed_pairs();
    set_idling(0, 0);
    send_pair(ID_IN_W'(0), ID_IN_W'(0), 1'b0);
    send_pair(ID_IN_W'(1023), ID_IN_W'(1023), 1'b0);
    send_pair(ID_IN_W'(0), ID_IN_W'(1023), 1'b0);
    send_pair(ID_IN_W'(1023), ID_IN_W'(0), 1'b0);
    send_pair(ID_IN_W'(10'h155), ID_IN_W'(10'h2AA), 1'b0);
    send_pair(ID_IN_W'(10'h2AA), ID_IN_W'(10'h155), 1'b0);
    send_pair(ID_IN_W'(10'h155), ID_IN_W'(0), 1'b0);
    // Build trees of different rank, then query through compressed paths.
    send_pair(ID_IN_W'(1), ID_IN_W'(2), 1'b0);
    send_pair(ID_IN_W'(3), ID_IN_W'(4), 1'b0);
    send_pair(ID_IN_W'(1), ID_IN_W'(3), 1'b0);
    send_pair(ID_IN_W'(5), ID_IN_W'(6), 1'b0);
    send_pair(ID_IN_W'(5), ID_IN_W'(1), 1'b0);
    send_pair(ID_IN_W'(6), ID_IN_W'(2), 1'b0);
    send_pair(ID_IN_W'(4), ID_IN_W'(10'h2AA), 1'b0);
    send_pair(ID_IN_W'(2), ID_IN_W'(1023), 1'b0);
    send_pair(ID_IN_W'(7), ID_IN_W'(7), 1'b1);
    send_pair(ID_IN_W'(0), ID_IN_W'(1023), 1'b0);
    send_pair(ID_IN_W'(1023), ID_IN_W'(1), 1'b1);
    send_pair(ID_IN_W'(1), ID_IN_W'(0), 1'b0);
  endtask

  // Enough clears to wrap the seen epoch at least once.
  task automatic test_epoch_wrap();
    set_idling(7, 7);
    for (int i = 0; i < 260; i++) begin
      send_pair(pick_node(), pick_node(), 1'b1);
      if (i % 8 == 7) begin
        send_pair(pick_node(), pick_node(), 1'b0);
      end
    end
  endtask

  task automatic test_random_merges();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          set_idling(0, 0);
        end
        1: begin
          set_idling(86, 0);
        end
        2: begin
          set_idling(0, 86);
        end
        default: begin
          set_idling(7, 7);
        end
      endcase
      for (int i = 0; i < 260; i++) begin
        send_pair(pick_node(), pick_node(), $urandom_range(0, 199) == 0);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_pairs();
    test_epoch_wrap();
    test_random_merges();
    in_valid <= 1'b0;
    while (pending_sizes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (64) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
